@@ hw/rtl/pcb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcb_pkg
// shared types and constants for the pre-trigger capture ring
// ----------------------------------------------------------------------------
package pcb_pkg;

    localparam int DEPTH_DEF       = 64;
    localparam int RECORD_BITS_DEF = 64;

    localparam int WORD_BITS  = 64;
    localparam int STATE_BITS = 4;

    localparam logic KIND_ADD  = 1'b0;
    localparam logic KIND_DUMP = 1'b1;

    typedef enum logic [1:0] {
        PCB_IDLE,
        PCB_READ,
        PCB_DRAIN
    } pcb_state_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } pcb_mem_cmd_t;

endpackage

@@ hw/rtl/pretrigger_capture_buffer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pretrigger_capture_buffer
// pre-trigger capture ring: adds overwrite the oldest slot, one dump oldest first
// ----------------------------------------------------------------------------
// add: busy stays low, so one add per clock while no dump is in progress
// dump of n records: busy through the last strobe, records strobed from registered reads,
// one per cycle after the accept, set by the single ring memory read port
// empty ring or frozen ring: no result, busy stays low
// reset clears position, wrap and dump flags at once; ring contents are not cleared
// results cannot be stalled: each strobe is a transfer in that cycle
module pretrigger_capture_buffer
    import pcb_pkg::*;
#(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int RECORD_BITS = RECORD_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  kind,
    input  logic [WORD_BITS-1:0]  record_word,
    input  logic [STATE_BITS-1:0] phase_tag,
    output logic                  strobe,
    output logic [WORD_BITS-1:0]  stored_record,
    output logic [STATE_BITS-1:0] stored_state,
    output logic                  last_of_dump
);

    localparam int PTR_W   = $clog2(DEPTH);
    localparam int ENTRY_W = RECORD_BITS + STATE_BITS;

    pcb_mem_cmd_t       cmd;
    logic [PTR_W-1:0]   wr_addr;
    logic [PTR_W-1:0]   rd_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic [ENTRY_W-1:0] rd_data;

    assign wr_data = {phase_tag, record_word[RECORD_BITS-1:0]};

    pcb_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .kind    (kind),
        .busy    (busy),
        .cmd     (cmd),
        .wr_addr (wr_addr),
        .rd_addr (rd_addr),
        .strobe  (strobe),
        .last    (last_of_dump)
    );

    pcb_ring_mem #(
        .DEPTH       (DEPTH),
        .RECORD_BITS (RECORD_BITS)
    ) u_mem (
        .clk     (clk),
        .cmd     (cmd),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign stored_record = WORD_BITS'(rd_data[RECORD_BITS-1:0]);
    assign stored_state  = rd_data[ENTRY_W-1:RECORD_BITS];

endmodule

@@ hw/rtl/pcb_ring_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcb_ring_mem
// ring storage: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module pcb_ring_mem
    import pcb_pkg::*;
#(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int RECORD_BITS = RECORD_BITS_DEF,
    localparam int PTR_W      = $clog2(DEPTH),
    localparam int ENTRY_W    = RECORD_BITS + STATE_BITS
)
(
    input  logic                   clk,
    input  pcb_mem_cmd_t           cmd,
    input  logic [PTR_W-1:0]       wr_addr,
    input  logic [ENTRY_W-1:0]     wr_data,
    input  logic [PTR_W-1:0]       rd_addr,
    output logic [ENTRY_W-1:0]     rd_data
);

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/pcb_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcb_ctrl
// write position, wrap and dump tracking, and the dump read sequencer
// ----------------------------------------------------------------------------
module pcb_ctrl
    import pcb_pkg::*;
#(
    parameter int DEPTH   = DEPTH_DEF,
    localparam int PTR_W  = $clog2(DEPTH),
    localparam int CNT_W  = $clog2(DEPTH + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             kind,
    output logic             busy,
    output pcb_mem_cmd_t     cmd,
    output logic [PTR_W-1:0] wr_addr,
    output logic [PTR_W-1:0] rd_addr,
    output logic             strobe,
    output logic             last
);

    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

    pcb_state_t       state_reg, state_next;
    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic             wrapped_reg, wrapped_next;
    logic             dumped_reg, dumped_next;
    logic [PTR_W-1:0] raddr_reg, raddr_next;
    logic [CNT_W-1:0] remain_reg, remain_next;
    logic             valid_reg, valid_next;
    logic             last_reg, last_next;

    logic             accept;
    logic [CNT_W-1:0] dump_cnt;

    assign busy     = (state_reg != PCB_IDLE);
    assign accept   = start && !busy;
    assign dump_cnt = wrapped_reg ? FULL_CNT : CNT_W'(wptr_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= PCB_IDLE;
            wptr_reg    <= '0;
            wrapped_reg <= 1'b0;
            dumped_reg  <= 1'b0;
            raddr_reg   <= '0;
            remain_reg  <= '0;
            valid_reg   <= 1'b0;
            last_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            wptr_reg    <= wptr_next;
            wrapped_reg <= wrapped_next;
            dumped_reg  <= dumped_next;
            raddr_reg   <= raddr_next;
            remain_reg  <= remain_next;
            valid_reg   <= valid_next;
            last_reg    <= last_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        wptr_next    = wptr_reg;
        wrapped_next = wrapped_reg;
        dumped_next  = dumped_reg;
        raddr_next   = raddr_reg;
        remain_next  = remain_reg;
        valid_next   = 1'b0;
        last_next    = 1'b0;
        cmd          = '0;

        case (state_reg)
            PCB_IDLE:
            begin
                // once dumped, every transfer is taken and dropped
                if (accept && !dumped_reg)
                begin
                    if (kind == KIND_ADD)
                    begin
                        cmd.wr_en = 1'b1;
                        if (wptr_reg == LAST_SLOT)
                        begin
                            wptr_next    = '0;
                            wrapped_next = 1'b1;
                        end
                        else
                        begin
                            wptr_next = wptr_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        dumped_next = 1'b1;
                        if (dump_cnt != '0)
                        begin
                            // oldest slot is the write position once wrapped
                            raddr_next  = wrapped_reg ? wptr_reg : '0;
                            remain_next = dump_cnt;
                            state_next  = PCB_READ;
                        end
                    end
                end
            end
            PCB_READ:
            begin
                cmd.rd_en   = 1'b1;
                valid_next  = 1'b1;
                last_next   = (remain_reg == CNT_W'(1));
                remain_next = remain_reg - 1'b1;
                raddr_next  = (raddr_reg == LAST_SLOT) ? '0 : raddr_reg + 1'b1;
                if (remain_reg == CNT_W'(1))
                begin
                    state_next = PCB_DRAIN;
                end
            end
            PCB_DRAIN:
            begin
                state_next = PCB_IDLE;
            end
            default:
            begin
                state_next = PCB_IDLE;
            end
        endcase
    end

    assign wr_addr = wptr_reg;
    assign rd_addr = raddr_reg;
    assign strobe  = valid_reg;
    assign last    = last_reg;

    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> busy)
        else $error("result strobe outside a dump");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && last_reg) |=> !valid_reg)
        else $error("result transfer after the last of a dump");

    a_dumped_holds: assert property (@(posedge clk) disable iff (!rst_n)
        dumped_reg |=> dumped_reg)
        else $error("dumped flag cleared without reset");

    a_no_write_in_dump: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_en |-> (!busy && !dumped_reg))
        else $error("ring write during or after a dump");

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (wptr_reg <= LAST_SLOT) && (raddr_reg <= LAST_SLOT))
        else $error("ring pointer beyond last slot");

endmodule

@@ sim/pcb_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcb_checker
// watches the item and readout channels of the capture ring, keeps its own
// copy of the ring, and compares every strobed record with the expected one
// ----------------------------------------------------------------------------
module pcb_checker
    import pcb_pkg::*;
#(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int RECORD_BITS = RECORD_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  logic                  kind,
    input  logic [WORD_BITS-1:0]  record_word,
    input  logic [STATE_BITS-1:0] phase_tag,
    input  logic                  strobe,
    input  logic [WORD_BITS-1:0]  stored_record,
    input  logic [STATE_BITS-1:0] stored_state,
    input  logic                  last_of_dump,
    output int                    errors,
    output int                    pending
);

    localparam logic [WORD_BITS-1:0] WORD_MASK = {WORD_BITS{1'b1}} >> (WORD_BITS - RECORD_BITS);

    typedef struct {
        logic [WORD_BITS-1:0]  word;
        logic [STATE_BITS-1:0] tag;
        logic                  last;
    } readout_t;

    logic [WORD_BITS-1:0]  ring_word [DEPTH];
    logic [STATE_BITS-1:0] ring_tag  [DEPTH];
    int                    wr_pos;
    bit                    wrapped;
    bit                    frozen;
    readout_t              readout_q [$];

    initial
    begin
        errors  = 0;
        pending = 0;
    end

    // one accepted item: store a record, or queue the whole readout
    task automatic capture_step(input logic k, input logic [WORD_BITS-1:0] w,
                                input logic [STATE_BITS-1:0] t);
        int first;
        int count;
        int slot;
        readout_t r;
        if (!frozen)
        begin
            if (k == KIND_ADD)
            begin
                ring_word[wr_pos] = w & WORD_MASK;
                ring_tag[wr_pos]  = t;
                wr_pos++;
                if (wr_pos == DEPTH)
                begin
                    wr_pos  = 0;
                    wrapped = 1'b1;
                end
            end
            else
            begin
                first = wrapped ? wr_pos : 0;
                count = wrapped ? DEPTH : wr_pos;
                for (int i = 0; i < count; i++)
                begin
                    slot   = (first + i) % DEPTH;
                    r.word = ring_word[slot];
                    r.tag  = ring_tag[slot];
                    r.last = (i == count - 1);
                    readout_q.push_back(r);
                end
                // even an empty dump freezes the ring
                frozen = 1'b1;
            end
        end
    endtask

    task automatic check_readout();
        readout_t exp_r;
        if (readout_q.size() == 0)
        begin
            errors++;
            $display("%0t: record %h state %h last %b strobed with none expected",
                     $time, stored_record, stored_state, last_of_dump);
        end
        else
        begin
            exp_r = readout_q.pop_front();
            if (stored_record !== exp_r.word)
            begin
                errors++;
                $display("%0t: stored_record expected %h actual %h",
                         $time, exp_r.word, stored_record);
            end
            if (stored_state !== exp_r.tag)
            begin
                errors++;
                $display("%0t: stored_state expected %h actual %h",
                         $time, exp_r.tag, stored_state);
            end
            if (last_of_dump !== exp_r.last)
            begin
                errors++;
                $display("%0t: last_of_dump expected %b actual %b",
                         $time, exp_r.last, last_of_dump);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_pos  = 0;
            wrapped = 1'b0;
            frozen  = 1'b0;
            readout_q.delete();
        end
        else
        begin
            if (strobe)
                check_readout();
            if (start && !busy)
                capture_step(kind, record_word, phase_tag);
        end
        pending = readout_q.size();
    end

endmodule

@@ sim/pretrigger_capture_buffer_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pretrigger_capture_buffer_test
// fills the capture ring with random and corner records (empty, partial, exact
// fill or many wraps, chosen per seed), dumps it once, then checks that later
// items are ignored; pcb_checker predicts and compares the readout
// ----------------------------------------------------------------------------
module pretrigger_capture_buffer_test;
    import pcb_pkg::*;

    localparam int DEPTH      = DEPTH_DEF;
    localparam int STALL_MAX  = 4000;
    localparam int TAIL_WAIT  = DEPTH + 20;
    localparam int ITEM_GOAL  = 260;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic                  kind;
    logic [WORD_BITS-1:0]  record_word;
    logic [STATE_BITS-1:0] phase_tag;
    logic                  strobe;
    logic [WORD_BITS-1:0]  stored_record;
    logic [STATE_BITS-1:0] stored_state;
    logic                  last_of_dump;
    int                    errors;
    int                    pending;
    int                    stall_cycles;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    pretrigger_capture_buffer u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .record_word  (record_word),
        .phase_tag    (phase_tag),
        .strobe       (strobe),
        .stored_record(stored_record),
        .stored_state (stored_state),
        .last_of_dump (last_of_dump)
    );

    pcb_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .record_word  (record_word),
        .phase_tag    (phase_tag),
        .strobe       (strobe),
        .stored_record(stored_record),
        .stored_state (stored_state),
        .last_of_dump (last_of_dump),
        .errors       (errors),
        .pending      (pending)
    );

    // watchdog: cycles with neither an item nor a record transfer
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || strobe)
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_MAX)
        begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_MAX);
            $display("*** FAILED ***");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // sender idles 34 percent, then 81 percent, then never
    function automatic int idle_pct(input int idx, input int total);
        if (idx < total / 3)
            return 34;
        else if (idx < (2 * total) / 3)
            return 81;
        return 0;
    endfunction

    task automatic send_item(input logic k, input logic [WORD_BITS-1:0] w,
                             input logic [STATE_BITS-1:0] t, input int pct);
        while ($urandom_range(0, 99) < pct)
        begin
            @(negedge clk);
            start        <= 1'b0;
            kind         <= 1'($urandom_range(0, 1));
            record_word  <= {$urandom, $urandom};
            phase_tag    <= 4'($urandom_range(0, 15));
        end
        @(negedge clk);
        start        <= 1'b1;
        kind         <= k;
        record_word  <= w;
        phase_tag    <= t;
        do
            @(posedge clk);
        while (busy);
    endtask

    initial
    begin
        int                    fill_mode;
        int                    n_adds;
        int                    n_after;
        int                    total;
        int                    idx;
        logic [WORD_BITS-1:0]  w;
        logic [STATE_BITS-1:0] t;

        stall_cycles = 0;
        rst_n        = 1'b0;
        start        = 1'b0;
        kind         = KIND_ADD;
        record_word  = '0;
        phase_tag    = '0;

        fill_mode = $urandom_range(0, 9);
        case (fill_mode)
            0:       n_adds = 0;                        // empty ring dump
            1:       n_adds = $urandom_range(1, DEPTH - 1);
            2:       n_adds = DEPTH;                    // exact fill, wraps to slot 0
            default: n_adds = $urandom_range(230, 290); // several wraps
        endcase
        // short fills are topped up with ignored items after the dump
        n_after = (n_adds < ITEM_GOAL - 11) ? ITEM_GOAL - 1 - n_adds : $urandom_range(10, 20);
        total   = n_adds + 1 + n_after;
        idx     = 0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // the newest adds carry corner values so the dump always reads them
        for (int i = 0; i < n_adds; i++)
        begin
            w = {$urandom, $urandom};
            t = 4'($urandom_range(0, 15));
            case (n_adds - 1 - i)
                0: begin w = '0;                      t = 4'h0; end
                1: begin w = '1;                      t = 4'hf; end
                2: begin w = {16{4'ha}};              t = 4'ha; end
                3: begin w = {16{4'h5}};              t = 4'h5; end
                4: begin w = {1'b1, {63{1'b0}}};      t = 4'h9; end
                5: begin w = {{63{1'b0}}, 1'b1};      t = 4'h6; end
                default: ;
            endcase
            send_item(KIND_ADD, w, t, idle_pct(idx, total));
            idx++;
        end

        send_item(KIND_DUMP, {$urandom, $urandom}, 4'($urandom_range(0, 15)),
                  idle_pct(idx, total));
        idx++;

        // hold off until the whole dump is out
        do
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        while (pending != 0);

        // ring is frozen now: none of these may produce a transfer
        for (int i = 0; i < n_after; i++)
        begin
            send_item(1'($urandom_range(0, 1)), {$urandom, $urandom},
                      4'($urandom_range(0, 15)), idle_pct(idx, total));
            idx++;
        end

        @(negedge clk);
        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (TAIL_WAIT) @(negedge clk);

        if (errors == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/pcb_pkg.sv
hw/rtl/pcb_ring_mem.sv
hw/rtl/pcb_ctrl.sv
hw/rtl/pretrigger_capture_buffer.sv
sim/pcb_checker.sv
sim/pretrigger_capture_buffer_test.sv
